// ----- hdl/odr_pkg.sv -----
// Shared types, constants and the arctangent table for the odometry block.
// Used by odr_cordic, odr_mul and odometry_dead_reckoning; depends on nothing.
`default_nettype none

package odr_pkg;

    // CORDIC datapath: Q2.30 values with guard bits, angles in binary-angle units.
    localparam int CORDIC_W = 34;
    // Trig results before clamping: Q1.15 that can reach +1.0.
    localparam int TRIG_W = 17;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Field widths.
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DT_W    = 16;
    localparam int POS_W   = 32;
    localparam int ANG_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int VEL_W   = 24;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET  = 16'd8192;  // 2.0 in Q4.12
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 16'd7127;  // 1.74 in Q4.12

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_GAIN  = 1'b0,
        REG_ANGULAR_GAIN = 1'b1
    } odr_cfg_reg_t;

    // Initial CORDIC x, the inverse of the rotator gain in Q2.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    // round(2^24 / (2*pi)), converts radians in Q8.24 into binary-angle units.
    localparam logic signed [MUL_B_W-1:0] INV_TWO_PI_Q24 = 24'sd2670177;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_V,
        ST_SCALE_W,
        ST_CAP_W,
        ST_WDT,
        ST_HDT,
        ST_HCAP,
        ST_WAIT_CS,
        ST_VC,
        ST_VCDT,
        ST_VS,
        ST_VSDT,
        ST_YCAP,
        ST_FINISH
    } odr_state_t;

    // Arctangent of 2^-i in binary-angle units (a full turn is 2^32).
    function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] r;
        unique case (idx)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2FA;
            5'd15: r = 34'sh00000517D;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A30;
            5'd19: r = 34'sh000000518;
            5'd20: r = 34'sh00000028C;
            5'd21: r = 34'sh000000146;
            5'd22: r = 34'sh0000000A3;
            5'd23: r = 34'sh000000051;
            5'd24: r = 34'sh000000029;
            5'd25: r = 34'sh000000014;
            5'd26: r = 34'sh00000000A;
            5'd27: r = 34'sh000000005;
            5'd28: r = 34'sh000000003;
            5'd29: r = 34'sh000000001;
            5'd30: r = 34'sh000000001;
            5'd31: r = 34'sh000000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/odometry_dead_reckoning.sv -----
// Top level of the dead-reckoning odometry block: sequencer, state and result registers.
// Depends on odr_pkg, odr_mul and odr_cordic.
`default_nettype none

// Unicycle-model odometry. Each input transaction carries a forward speed (Q8.8),
// a yaw rate (Q8.8) and the elapsed time (Q0.16 s). Both speeds are scaled by the
// linear_gain and angular_gain registers (Q4.12, index 0 and 1 on the configuration
// port). Position is advanced along the heading held before the transaction, then the
// heading advances by the scaled yaw rate times the elapsed time; the heading is a
// 32-bit binary angle that wraps, and the positions saturate. Every input transaction
// produces exactly one result transaction with the negated position, the heading, the
// yaw quaternion of the new heading and the negated scaled speeds. The block handles one
// transaction at a time: item_stall is high from acceptance until the result has been
// placed in the output register. The length of the stall is set by two passes through
// the single iterative CORDIC rotator, one micro-rotation per cycle; the shared
// multiplier work fits beneath them. If the previous result is still held in the output
// register, the stall lasts until it is taken. A finished result waits in the output
// register while the next transaction is taken. cfg_ready is always high; write the
// gains only while no transaction is in flight.
module odometry_dead_reckoning #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic signed [odr_pkg::SPEED_W-1:0]    linear_speed,
    input  wire logic signed [odr_pkg::SPEED_W-1:0]    turn_rate,
    input  wire logic [odr_pkg::DT_W-1:0]              elapsed_time,

    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic signed [odr_pkg::POS_W-1:0]           neg_pos_x,
    output logic signed [odr_pkg::POS_W-1:0]           neg_pos_y,
    output logic [odr_pkg::ANG_W-1:0]                  heading_angle,
    output logic signed [odr_pkg::QUAT_W-1:0]          quat_z,
    output logic signed [odr_pkg::QUAT_W-1:0]          quat_w,
    output logic signed [odr_pkg::VEL_W-1:0]           neg_linear,
    output logic signed [odr_pkg::VEL_W-1:0]           neg_angular,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [odr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [odr_pkg::GAIN_W-1:0]            cfg_data
);
    import odr_pkg::*;

    // Saturating add of a position delta to a Q16.16 position.
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] pos,
        input logic signed [POS_W:0]   delta
    );
        logic signed [POS_W+1:0] sum;
        logic signed [POS_W-1:0] r;
        sum = (POS_W+2)'(pos) + (POS_W+2)'(delta);
        if (sum > (POS_W+2)'(34'sh07FFFFFFF))
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (sum < (POS_W+2)'(-34'sh080000000))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = sum[POS_W-1:0];
        end
        return r;
    endfunction

    // Negation that maps the most negative position onto the most positive one.
    function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [POS_W-1:0] pos);
        logic signed [POS_W-1:0] r;
        if (pos == 32'sh8000_0000)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else
        begin
            r = -pos;
        end
        return r;
    endfunction

    // Clamp of a trig value to the Q1.15 range; only +1.0 actually reaches the limit.
    function automatic logic signed [QUAT_W-1:0] clamp_q15(input logic signed [TRIG_W-1:0] v);
        logic signed [QUAT_W-1:0] r;
        if (v > 17'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -17'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[QUAT_W-1:0];
        end
        return r;
    endfunction

    // Sequencer and configuration state.
    odr_state_t                 state_reg, state_next;
    logic [GAIN_W-1:0]          lin_gain_reg, lin_gain_next;
    logic [GAIN_W-1:0]          ang_gain_reg, ang_gain_next;

    // Odometry state.
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [ANG_W-1:0]           heading_reg, heading_next;

    // Working registers of the transaction in flight.
    logic signed [SPEED_W-1:0]  speed_reg, speed_next;
    logic signed [SPEED_W-1:0]  turn_reg, turn_next;
    logic [DT_W-1:0]            dt_reg, dt_next;
    logic signed [VEL_W-1:0]    v_reg, v_next;
    logic signed [VEL_W-1:0]    w_reg, w_next;
    logic signed [TRIG_W-1:0]   cos_reg, cos_next;
    logic signed [TRIG_W-1:0]   sin_reg, sin_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]    out_x_reg, out_x_next;
    logic signed [POS_W-1:0]    out_y_reg, out_y_next;
    logic [ANG_W-1:0]           out_head_reg, out_head_next;
    logic signed [QUAT_W-1:0]   out_qz_reg, out_qz_next;
    logic signed [QUAT_W-1:0]   out_qw_reg, out_qw_next;
    logic signed [VEL_W-1:0]    out_lin_reg, out_lin_next;
    logic signed [VEL_W-1:0]    out_ang_reg, out_ang_next;

    // Shared multiplier and CORDIC hookup.
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;
    logic                       cordic_start;
    logic [ANG_W-1:0]           cordic_angle;
    logic                       cordic_busy;
    logic signed [TRIG_W-1:0]   cordic_sin;
    logic signed [TRIG_W-1:0]   cordic_cos;

    // Rounded views of the product register.
    logic signed [MUL_P_W-1:0]  scale_rnd;
    logic signed [MUL_P_W-1:0]  delta_rnd;
    logic signed [MUL_P_W-1:0]  head_rnd;
    logic signed [VEL_W-1:0]    scaled;
    logic signed [POS_W:0]      pos_delta;
    logic [ANG_W-1:0]           head_delta;

    logic                       accept;
    logic                       out_free;

    odr_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    odr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .busy    (cordic_busy),
        .sin_val (cordic_sin),
        .cos_val (cordic_cos)
    );

    // Speed * gain (Q8.8 * Q4.12) rounds by 12 bits to Q16.8. The position term
    // v * trig * dt (Q16.8 * Q1.15 * Q0.16) rounds by 23 bits to Q16.16. The heading
    // term w * dt * 2^24/(2*pi) rounds by 16 bits to binary-angle units.
    always_comb
    begin
        scale_rnd  = (prod + 66'sd2048) >>> 12;
        delta_rnd  = (prod + 66'sd4194304) >>> 23;
        head_rnd   = (prod + 66'sd32768) >>> 16;
        scaled     = scale_rnd[VEL_W-1:0];
        pos_delta  = delta_rnd[POS_W:0];
        head_delta = head_rnd[ANG_W-1:0];
    end

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !result_stall;

    // Sequencer. Each multiplication is issued in one state and its product is used
    // in the next one. The first CORDIC pass, on the old heading, starts when the
    // transaction is accepted and runs beside the speed and heading arithmetic. The
    // second pass, on half the new heading, runs beside the position updates.
    always_comb
    begin
        state_next     = state_reg;
        lin_gain_next  = lin_gain_reg;
        ang_gain_next  = ang_gain_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        speed_next     = speed_reg;
        turn_next      = turn_reg;
        dt_next        = dt_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_head_next  = out_head_reg;
        out_qz_next    = out_qz_reg;
        out_qw_next    = out_qw_reg;
        out_lin_next   = out_lin_reg;
        out_ang_next   = out_ang_reg;

        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        cordic_angle = heading_reg;

        // The pending result leaves when the downstream side takes it.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINEAR_GAIN:  lin_gain_next = cfg_data;
                REG_ANGULAR_GAIN: ang_gain_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    speed_next   = linear_speed;
                    turn_next    = turn_rate;
                    dt_next      = elapsed_time;
                    cordic_start = 1'b1;
                    cordic_angle = heading_reg;
                    state_next   = ST_SCALE_V;
                end
            end
            ST_SCALE_V:
            begin
                mul_a      = MUL_A_W'(speed_reg);
                mul_b      = MUL_B_W'(lin_gain_reg);
                state_next = ST_SCALE_W;
            end
            ST_SCALE_W:
            begin
                v_next     = scaled;
                mul_a      = MUL_A_W'(turn_reg);
                mul_b      = MUL_B_W'(ang_gain_reg);
                state_next = ST_CAP_W;
            end
            ST_CAP_W:
            begin
                w_next     = scaled;
                state_next = ST_WDT;
            end
            ST_WDT:
            begin
                mul_a      = MUL_A_W'(dt_reg);
                mul_b      = w_reg;
                state_next = ST_HDT;
            end
            ST_HDT:
            begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = INV_TWO_PI_Q24;
                state_next = ST_HCAP;
            end
            ST_HCAP:
            begin
                // The first CORDIC pass already holds the old heading.
                heading_next = heading_reg + head_delta;
                state_next   = ST_WAIT_CS;
            end
            ST_WAIT_CS:
            begin
                if (!cordic_busy)
                begin
                    cos_next     = cordic_cos;
                    sin_next     = cordic_sin;
                    cordic_start = 1'b1;
                    cordic_angle = heading_reg >> 1;
                    state_next   = ST_VC;
                end
            end
            ST_VC:
            begin
                mul_a      = MUL_A_W'(cos_reg);
                mul_b      = v_reg;
                state_next = ST_VCDT;
            end
            ST_VCDT:
            begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = MUL_B_W'(dt_reg);
                state_next = ST_VS;
            end
            ST_VS:
            begin
                pos_x_next = sat_add(pos_x_reg, pos_delta);
                mul_a      = MUL_A_W'(sin_reg);
                mul_b      = v_reg;
                state_next = ST_VSDT;
            end
            ST_VSDT:
            begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = MUL_B_W'(dt_reg);
                state_next = ST_YCAP;
            end
            ST_YCAP:
            begin
                pos_y_next = sat_add(pos_y_reg, pos_delta);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Load the output register once the quaternion is ready and the
                // previous result has been taken (or is taken at this edge).
                if (!cordic_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = neg_sat(pos_x_reg);
                    out_y_next     = neg_sat(pos_y_reg);
                    out_head_next  = heading_reg;
                    out_qz_next    = clamp_q15(cordic_sin);
                    out_qw_next    = clamp_q15(cordic_cos);
                    out_lin_next   = -v_reg;
                    out_ang_next   = -w_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lin_gain_reg  <= LINEAR_GAIN_RESET;
            ang_gain_reg  <= ANGULAR_GAIN_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lin_gain_reg  <= lin_gain_next;
            ang_gain_reg  <= ang_gain_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg    <= speed_next;
        turn_reg     <= turn_next;
        dt_reg       <= dt_next;
        v_reg        <= v_next;
        w_reg        <= w_next;
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_head_reg <= out_head_next;
        out_qz_reg   <= out_qz_next;
        out_qw_reg   <= out_qw_next;
        out_lin_reg  <= out_lin_next;
        out_ang_reg  <= out_ang_next;
    end

    assign item_stall    = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = out_valid_reg;
    assign neg_pos_x     = out_x_reg;
    assign neg_pos_y     = out_y_reg;
    assign heading_angle = out_head_reg;
    assign quat_z        = out_qz_reg;
    assign quat_w        = out_qw_reg;
    assign neg_linear    = out_lin_reg;
    assign neg_angular   = out_ang_reg;

endmodule

`default_nettype wire

// ----- hdl/odr_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on odr_pkg for operand and product widths.
`default_nettype none

module odr_mul (
    input  wire logic                               clk,
    input  wire logic signed [odr_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [odr_pkg::MUL_B_W-1:0] b,
    output logic signed [odr_pkg::MUL_P_W-1:0]      prod
);
    import odr_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    always_comb
    begin
        prod_next = a * b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- hdl/odr_cordic.sv -----
// Iterative CORDIC rotator: one micro-rotation per cycle, sine and cosine in Q1.15.
// Depends on odr_pkg for widths, the start gain and the arctangent table.
`default_nettype none

module odr_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [odr_pkg::ANG_W-1:0]         angle,
    output logic                                   busy,
    output logic signed [odr_pkg::TRIG_W-1:0]      sin_val,
    output logic signed [odr_pkg::TRIG_W-1:0]      cos_val
);
    import odr_pkg::*;

    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    logic                       busy_reg, busy_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       flip_reg, flip_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;

    logic [ANG_W-1:0]           quad_sum;
    logic [ANG_W-1:0]           folded;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [CORDIC_W-1:0] atan_val;
    logic signed [CORDIC_W-1:0] x_rnd;
    logic signed [CORDIC_W-1:0] y_rnd;
    logic signed [TRIG_W-1:0]   cos_raw;
    logic signed [TRIG_W-1:0]   sin_raw;

    always_comb
    begin
        // Angles in the left half plane are rotated by half a turn and the result negated.
        quad_sum = angle + 32'h4000_0000;
        folded   = angle ^ {quad_sum[ANG_W-1], {(ANG_W-1){1'b0}}};

        xs       = x_reg >>> iter_reg;
        ys       = y_reg >>> iter_reg;
        atan_val = atan_angle(5'(iter_reg));

        busy_next = busy_reg;
        iter_next = iter_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            flip_next = quad_sum[ANG_W-1];
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = CORDIC_W'(signed'(folded));
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_val;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_LAST)
            begin
                busy_next = 1'b0;
            end
        end

        x_rnd   = (x_reg + 34'sd16384) >>> 15;
        y_rnd   = (y_reg + 34'sd16384) >>> 15;
        cos_raw = x_rnd[TRIG_W-1:0];
        sin_raw = y_rnd[TRIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign busy    = busy_reg;
    assign cos_val = flip_reg ? -cos_raw : cos_raw;
    assign sin_val = flip_reg ? -sin_raw : sin_raw;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for odometry_dead_reckoning: it drives odometry updates and gain writes,
// predicts every pose and compares it field by field. Depends on odr_pkg and the block's RTL.
`default_nettype none

module tb;

    import odr_pkg::*;

    // The block runs with its default number of micro-rotations; the predictor uses the same count.
    localparam int ROTATIONS = 16;
    // Wait at the end of the run: room for one transaction inside the block, with margin on top.
    localparam int SETTLE_CYCLES = 2 * ROTATIONS + 10;
    // Longest legal quiet stretch is the deliberate receiver hold plus one computation.
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int IDLE_PERCENT = 32;
    localparam int PHASE_ITEMS = 170;

    localparam longint POS_MIN = -(longint'(1) <<< 31);
    localparam longint POS_MAX = (longint'(1) <<< 31) - 1;
    localparam longint VEL_MIN = -(longint'(1) <<< 23);
    localparam longint VEL_MAX = (longint'(1) <<< 23) - 1;
    localparam longint ROTATOR_START_X = 64'sd652032874;
    localparam longint RAD_TO_BAM_Q24 = 64'sd2670177;

    // Arctangent of 2^-i as a binary angle, one entry per micro-rotation.
    localparam longint ARCTAN_BAM [ROTATIONS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // One entry of the drive plan: either a gain write or an odometry update.
    typedef struct {
        bit                       is_gain_write;
        odr_cfg_reg_t             gain_sel;
        logic [GAIN_W-1:0]        gain_value;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] rate;
        logic [DT_W-1:0]          dt;
    } plan_entry_t;

    // One predicted pose, laid out like the block's result ports.
    typedef struct {
        logic signed [POS_W-1:0]  nx;
        logic signed [POS_W-1:0]  ny;
        logic [ANG_W-1:0]         heading;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
        logic signed [VEL_W-1:0]  n_lin;
        logic signed [VEL_W-1:0]  n_ang;
    } pose_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                      item_valid = 1'b0;
    logic                      item_stall;
    logic signed [SPEED_W-1:0] linear_speed = '0;
    logic signed [SPEED_W-1:0] turn_rate = '0;
    logic [DT_W-1:0]           elapsed_time = '0;

    logic                      result_valid;
    logic                      result_stall = 1'b1;
    logic signed [POS_W-1:0]   neg_pos_x;
    logic signed [POS_W-1:0]   neg_pos_y;
    logic [ANG_W-1:0]          heading_angle;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [VEL_W-1:0]   neg_linear;
    logic signed [VEL_W-1:0]   neg_angular;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [GAIN_W-1:0]         cfg_data = '0;

    odometry_dead_reckoning #(
        .CORDIC_STEPS (ROTATIONS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .linear_speed  (linear_speed),
        .turn_rate     (turn_rate),
        .elapsed_time  (elapsed_time),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .neg_pos_x     (neg_pos_x),
        .neg_pos_y     (neg_pos_y),
        .heading_angle (heading_angle),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .neg_linear    (neg_linear),
        .neg_angular   (neg_angular),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive plan filled up front, and the poses still owed by the block, oldest first.
    plan_entry_t drive_plan[$];
    pose_t       owed_poses[$];

    // Shadow copy of the block's gains and accumulated pose.
    logic [GAIN_W-1:0] lin_gain_shadow = LINEAR_GAIN_RESET;
    logic [GAIN_W-1:0] ang_gain_shadow = ANGULAR_GAIN_RESET;
    longint            track_x = 0;
    longint            track_y = 0;
    logic [ANG_W-1:0]  track_heading = '0;

    // Handshake outcomes seen at the last rising edge, read by the driver on the falling edge.
    bit item_took = 1'b0;
    bit gain_took = 1'b0;

    int updates_taken = 0;
    int poses_seen = 0;
    int gain_writes = 0;
    int mismatches = 0;
    int heading_wraps = 0;
    int clamped_steps = 0;
    int quiet_cycles = 0;

    // Both sides run without any idling while the update count sits in this window.
    wire calm = (updates_taken >= 550) && (updates_taken < 750);

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round half up while dropping s fraction bits; >>> on a longint floors.
    function automatic longint round_drop(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Sine and cosine of a binary angle in Q1.15. The rotator only converges within a
    // quarter turn either side of zero, so angles in the back half are turned by a half
    // turn first and the results negated afterwards.
    function automatic void cordic_sincos(input logic [ANG_W-1:0] ang,
                                          output longint s, output longint c);
        logic            flip;
        logic [ANG_W-1:0] folded;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        flip = ang[ANG_W-1] ^ ang[ANG_W-2];
        folded = flip ? ang - 32'h8000_0000 : ang;
        z = longint'($signed(folded));
        x = ROTATOR_START_X;
        y = 0;
        for (int i = 0; i < ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_BAM[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_BAM[i];
            end
        end
        x = round_drop(x, 15);
        y = round_drop(y, 15);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_by_gain(input logic signed [SPEED_W-1:0] raw,
                                             input logic [GAIN_W-1:0] gain);
        return clip(round_drop(longint'(raw) * longint'(gain), 12), VEL_MIN, VEL_MAX);
    endfunction

    // Advances the shadow pose by one update and returns the pose the block must report.
    // Position moves along the heading held before the update; the heading moves after.
    function automatic pose_t advance_odometry(input logic signed [SPEED_W-1:0] speed,
                                               input logic signed [SPEED_W-1:0] rate,
                                               input logic [DT_W-1:0] dt);
        pose_t            p;
        longint           v;
        longint           w;
        longint           dtl;
        longint           s;
        longint           c;
        longint           qz;
        longint           qw;
        longint           nx_raw;
        longint           ny_raw;
        longint           dh;
        logic [ANG_W-1:0] old_heading;
        v = scale_by_gain(speed, lin_gain_shadow);
        w = scale_by_gain(rate, ang_gain_shadow);
        dtl = longint'(dt);

        cordic_sincos(track_heading, s, c);
        nx_raw = track_x + round_drop(v * c * dtl, 23);
        ny_raw = track_y + round_drop(v * s * dtl, 23);
        if (nx_raw != clip(nx_raw, POS_MIN, POS_MAX) || ny_raw != clip(ny_raw, POS_MIN, POS_MAX))
            clamped_steps++;
        track_x = clip(nx_raw, POS_MIN, POS_MAX);
        track_y = clip(ny_raw, POS_MIN, POS_MAX);

        dh = round_drop(w * dtl * RAD_TO_BAM_Q24, 16);
        old_heading = track_heading;
        track_heading = track_heading + dh[ANG_W-1:0];
        if ((dh > 0 && track_heading < old_heading) || (dh < 0 && track_heading > old_heading))
            heading_wraps++;

        // The quaternion uses half of the wrapped heading, so qz never goes negative.
        cordic_sincos(track_heading >> 1, qz, qw);
        p.nx      = POS_W'(clip(-track_x, POS_MIN, POS_MAX));
        p.ny      = POS_W'(clip(-track_y, POS_MIN, POS_MAX));
        p.heading = track_heading;
        p.qz      = QUAT_W'(clip(qz, -32768, 32767));
        p.qw      = QUAT_W'(clip(qw, -32768, 32767));
        p.n_lin   = VEL_W'(-v);
        p.n_ang   = VEL_W'(-w);
        return p;
    endfunction

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Input side, sampled at the rising edge. Gain writes update the shadow registers, every
    // accepted update is predicted at once, and each result transaction is matched against
    // the oldest owed pose. A watchdog counts edges where nothing at all was accepted.
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n)
        begin
            item_took = item_valid && !item_stall;
            gain_took = cfg_valid && cfg_ready;

            if (result_valid && !result_stall)
            begin
                poses_seen++;
                if (owed_poses.size() == 0)
                begin
                    $error("result transaction with no pose owed");
                    mismatches++;
                end
                else
                begin
                    want = owed_poses.pop_front();
                    check_field("neg_pos_x", want.nx, neg_pos_x);
                    check_field("neg_pos_y", want.ny, neg_pos_y);
                    check_field("heading_angle", want.heading, heading_angle);
                    check_field("quat_z", POS_W'(want.qz), POS_W'(quat_z));
                    check_field("quat_w", POS_W'(want.qw), POS_W'(quat_w));
                    check_field("neg_linear", POS_W'(want.n_lin), POS_W'(neg_linear));
                    check_field("neg_angular", POS_W'(want.n_ang), POS_W'(neg_angular));
                end
            end

            if (gain_took)
            begin
                gain_writes++;
                if (odr_cfg_reg_t'(cfg_index) == REG_LINEAR_GAIN)
                    lin_gain_shadow = cfg_data;
                else
                    ang_gain_shadow = cfg_data;
            end

            if (item_took)
            begin
                updates_taken++;
                owed_poses.push_back(advance_odometry(linear_speed, turn_rate, elapsed_time));
            end

            if (item_took || gain_took || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d poses still owed",
                         quiet_cycles, owed_poses.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Driver, on the falling edge. A valid that was not taken keeps its payload. A gain write
    // waits until the block owes no pose, so it never lands on an update in flight. Updates
    // are offered with random idle cycles except inside the calm window.
    always @(negedge clk)
    begin
        plan_entry_t nxt;
        logic        drive_item;
        logic        drive_gain;
        logic        load_item;
        logic        load_gain;
        if (rst_n)
        begin
            drive_item = item_valid && !item_took;
            drive_gain = cfg_valid && !gain_took;
            load_item = 1'b0;
            load_gain = 1'b0;
            if (!drive_item && !drive_gain && drive_plan.size() != 0)
            begin
                if (drive_plan[0].is_gain_write)
                begin
                    if (owed_poses.size() == 0)
                    begin
                        nxt = drive_plan.pop_front();
                        drive_gain = 1'b1;
                        load_gain = 1'b1;
                    end
                end
                else if (calm || $urandom_range(99) >= IDLE_PERCENT)
                begin
                    nxt = drive_plan.pop_front();
                    drive_item = 1'b1;
                    load_item = 1'b1;
                end
            end
            item_valid <= drive_item;
            cfg_valid <= drive_gain;
            if (load_item)
            begin
                linear_speed <= nxt.speed;
                turn_rate <= nxt.rate;
                elapsed_time <= nxt.dt;
            end
            if (load_gain)
            begin
                cfg_index <= nxt.gain_sel;
                cfg_data <= nxt.gain_value;
            end
        end
    end

    // Receiver stall, on the falling edge. Once, after a few hundred poses, the receiver holds
    // off for a long stretch so that the output register fills and the block stalls its input.
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        logic next_stall;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (!hold_done && poses_seen >= 300 && !calm)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                next_stall = 1'b1;
            end
            else
            begin
                next_stall = !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
            result_stall <= next_stall;
        end
    end

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        case ($urandom_range(3))
            0: return SPEED_W'($urandom());
            1: return SPEED_W'($urandom_range(1500));
            2: return -SPEED_W'($urandom_range(1500));
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(5))
            0: return '0;
            1: return 16'hFFFF;
            2, 3: return DT_W'($urandom_range(2000, 1));
            default: return DT_W'($urandom());
        endcase
    endfunction

    task automatic plan_update(input logic signed [SPEED_W-1:0] speed,
                               input logic signed [SPEED_W-1:0] rate,
                               input logic [DT_W-1:0] dt);
        plan_entry_t e;
        e.is_gain_write = 1'b0;
        e.gain_sel = REG_LINEAR_GAIN;
        e.gain_value = '0;
        e.speed = speed;
        e.rate = rate;
        e.dt = dt;
        drive_plan.push_back(e);
    endtask

    task automatic plan_gains(input logic [GAIN_W-1:0] lin, input logic [GAIN_W-1:0] ang);
        plan_entry_t e;
        e.is_gain_write = 1'b1;
        e.speed = '0;
        e.rate = '0;
        e.dt = '0;
        e.gain_sel = REG_LINEAR_GAIN;
        e.gain_value = lin;
        drive_plan.push_back(e);
        e.gain_sel = REG_ANGULAR_GAIN;
        e.gain_value = ang;
        drive_plan.push_back(e);
    endtask

    // Stimulus plan, reset and end of run.
    initial
    begin
        logic [GAIN_W-1:0] phase_lin [6];
        logic [GAIN_W-1:0] phase_ang [6];

        // Directed part. With the largest linear gain and no turn gain the heading stays at
        // zero while full reverse speed drives x into its negative limit, so the negated
        // position saturates; the zero heading also puts quat_w at +1.0, which must clamp.
        plan_gains(16'hFFFF, 16'h0000);
        plan_update(16'sh7FFF, 16'sh7FFF, 16'h0000);
        for (int i = 0; i < 17; i++)
            plan_update(16'sh8000, SPEED_W'($urandom()), 16'hFFFF);
        plan_update(16'sh8000, 16'sh8000, 16'h0000);
        // Back at the reset gains: extremes of every field and heading jumps past a full turn.
        plan_gains(LINEAR_GAIN_RESET, ANGULAR_GAIN_RESET);
        plan_update(16'sh0000, 16'sh0000, 16'hFFFF);
        plan_update(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        plan_update(16'sh8000, 16'sh8000, 16'hFFFF);
        plan_update(-16'sd1, 16'sd1, 16'h8000);
        plan_update(16'sd1, -16'sd1, 16'h0001);
        plan_update(16'sd100, 16'sh7FFF, 16'hFFFF);

        // Random phases, each under its own gain setting, the extremes among them.
        phase_lin = '{16'hFFFF, 16'h0000, 16'h1000, 16'h0000, LINEAR_GAIN_RESET, 16'h0000};
        phase_ang = '{16'hFFFF, 16'h0000, 16'h1000, 16'h0000, ANGULAR_GAIN_RESET, 16'h0000};
        phase_lin[3] = GAIN_W'($urandom());
        phase_ang[3] = GAIN_W'($urandom());
        phase_lin[5] = GAIN_W'($urandom());
        phase_ang[5] = GAIN_W'($urandom());
        for (int ph = 0; ph < 6; ph++)
        begin
            plan_gains(phase_lin[ph], phase_ang[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                plan_update(pick_speed(), pick_speed(), pick_dt());
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (drive_plan.size() != 0 || item_valid || cfg_valid || owed_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d odometry updates over %0d gain writes, %0d poses compared.",
                 updates_taken, gain_writes, poses_seen);
        $display("Heading wrapped %0d times; %0d updates hit the position limits.",
                 heading_wraps, clamped_steps);
        if (mismatches == 0 && owed_poses.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
